// ===== rtl/core/tsas_pkg.sv =====
// Shared types and constants for the touch sample averaging and scaling block.
`default_nettype none
package tsas_pkg;

  localparam int DATA_W    = 16;
  // Samples per burst; must be a power of two so the mean is a plain shift.
  localparam int BURST_LEN = 16;
  localparam int CNT_W     = $clog2(BURST_LEN);
  localparam int SUM_W     = DATA_W + CNT_W;
  localparam int STEP_W    = $clog2(DATA_W);
  localparam int CFG_AW    = 3;

  localparam logic [CFG_AW-1:0] REG_MIN_X      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_X      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_Y      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_Y      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SCALE_X    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SCALE_Y    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_REPORT_RAW = 3'd6;

  typedef struct packed {
    logic              pressed;
    logic [DATA_W-1:0] x_sample;
    logic [DATA_W-1:0] y_sample;
  } in_t;

  typedef struct packed {
    logic              touch_ok;
    logic [DATA_W-1:0] x_out;
    logic [DATA_W-1:0] y_out;
    logic [DATA_W-1:0] x_low_seen;
    logic [DATA_W-1:0] x_high_seen;
    logic [DATA_W-1:0] y_low_seen;
    logic [DATA_W-1:0] y_high_seen;
  } out_t;

  typedef struct packed {
    logic acc;
    logic clr;
    logic load_mean;
    logic clamp;
    logic mul;
    logic div_step;
    logic fin;
  } lane_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] sc;
    logic              raw;
  } lane_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
  } lane_res_t;

  typedef struct packed {
    logic load;
    logic ok;
  } merge_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/touch_sample_average_scale.sv =====
// Touch averaging top level: config registers, burst sequencer, X and Y lanes, merge stage.
// Result path: a burst-ending sample passes through mean load, clamp, multiply, 16 serial
//   divide steps and the merge register; a release result is registered the cycle after it is accepted.
// Throughput: one sample per cycle within a burst while no result is stalled; the lanes'
//   16-step divider then holds off input until each completed burst's result is loaded.
// Reset: synchronous active-low rst_n clears the sums, count, output valid and extreme
//   tracks, and loads the register defaults.
`default_nettype none
module touch_sample_average_scale
  import tsas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_ACC   = 5'b00001,
    S_CLAMP = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [DATA_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r, scale_x_r, scale_y_r;
  logic              raw_r;

  logic       in_fire;
  logic       out_free;
  logic       last_sample;
  lane_ctl_t  lane_ctl;
  lane_cfg_t  x_cfg, y_cfg;
  lane_res_t  x_res, y_res;
  merge_ctl_t merge_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r   <= '0;
      max_x_r   <= '1;
      min_y_r   <= '0;
      max_y_r   <= '1;
      scale_x_r <= DATA_W'(240);
      scale_y_r <= DATA_W'(320);
      raw_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_X:      min_x_r   <= cfg_wdata;
        REG_MAX_X:      max_x_r   <= cfg_wdata;
        REG_MIN_Y:      min_y_r   <= cfg_wdata;
        REG_MAX_Y:      max_y_r   <= cfg_wdata;
        REG_SCALE_X:    scale_x_r <= cfg_wdata;
        REG_SCALE_Y:    scale_y_r <= cfg_wdata;
        REG_REPORT_RAW: raw_r     <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  // a transaction that may emit a result needs the output register free
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state_r == S_ACC) && (out_free || (count_r == '0));
  assign in_fire     = in_valid && in_ready;
  assign last_sample = (count_r == CNT_W'(BURST_LEN - 1));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    lane_ctl  = '0;
    merge_ctl = '0;
    case (state_r)
      S_ACC: begin
        if (in_fire) begin
          if (!in_data.pressed) begin
            if (count_r != '0) begin
              lane_ctl.clr  = 1'b1;
              merge_ctl.load = 1'b1;
              count_nxt     = '0;
            end
          end else if (last_sample) begin
            lane_ctl.load_mean = 1'b1;
            count_nxt          = '0;
            state_nxt          = S_CLAMP;
          end else begin
            lane_ctl.acc = 1'b1;
            count_nxt    = count_r + 1'b1;
          end
        end
      end
      S_CLAMP: begin
        lane_ctl.clamp = 1'b1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        lane_ctl.mul = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        lane_ctl.div_step = 1'b1;
        step_nxt          = step_r + 1'b1;
        if (step_r == STEP_W'(DATA_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        lane_ctl.fin   = 1'b1;
        merge_ctl.load = 1'b1;
        merge_ctl.ok   = 1'b1;
        state_nxt      = S_ACC;
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
    end
  end

  assign x_cfg = '{lo: min_x_r, hi: max_x_r, sc: scale_x_r, raw: raw_r};
  assign y_cfg = '{lo: min_y_r, hi: max_y_r, sc: scale_y_r, raw: raw_r};

  tsas_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .cfg    (x_cfg),
    .sample (in_data.x_sample),
    .res    (x_res)
  );

  tsas_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .cfg    (y_cfg),
    .sample (in_data.y_sample),
    .res    (y_res)
  );

  tsas_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .x_res     (x_res),
    .y_res     (y_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tsas_lane.sv =====
// One axis lane: burst sum, mean, clamp, scale multiply, serial divide, extreme tracking.
`default_nettype none
module tsas_lane
  import tsas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lane_ctl_t         ctl,
  input  wire lane_cfg_t         cfg,
  input  wire logic [DATA_W-1:0] sample,
  output lane_res_t              res
);

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DATA_W-1:0] mean_r;
  logic [DATA_W-1:0] diff_r;
  logic [DATA_W-1:0] den_r;
  logic              empty_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] low_r;
  logic [DATA_W-1:0] high_r;
  logic [DATA_W-1:0] clamped;
  logic [2*DATA_W-1:0] product;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_sub;
  logic              trial_ge;
  logic              track_en;

  assign sum_nxt = sum_r + {{CNT_W{1'b0}}, sample};

  always_comb begin
    if (mean_r < cfg.lo) begin
      clamped = cfg.lo;
    end else if (mean_r > cfg.hi) begin
      clamped = cfg.hi;
    end else begin
      clamped = mean_r;
    end
  end

  assign product   = {{DATA_W{1'b0}}, diff_r} * {{DATA_W{1'b0}}, cfg.sc};
  // restoring step; remainder stays below the divisor unless the window is empty
  assign trial     = {rem_r, quo_r[DATA_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign trial_ge  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.clr || ctl.load_mean) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mean) begin
      mean_r <= sum_nxt[CNT_W +: DATA_W];
    end
    if (ctl.clamp) begin
      diff_r  <= clamped - cfg.lo;
      den_r   <= cfg.hi - cfg.lo;
      empty_r <= (cfg.hi <= cfg.lo);
    end
    if (ctl.mul) begin
      rem_r <= product[2*DATA_W-1:DATA_W];
      quo_r <= product[DATA_W-1:0];
    end else if (ctl.div_step) begin
      rem_r <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], trial_ge};
    end
  end

  assign track_en = ctl.fin && cfg.raw;

  always_comb begin
    res.value = cfg.raw ? mean_r : (empty_r ? '0 : quo_r);
    res.low   = (track_en && (mean_r < low_r))  ? mean_r : low_r;
    res.high  = (track_en && (mean_r > high_r)) ? mean_r : high_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '1;
      high_r <= '0;
    end else begin
      low_r  <= res.low;
      high_r <= res.high;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsas_merge.sv =====
// Merge stage: combines both lanes into one result and holds it in the output register.
`default_nettype none
module tsas_merge
  import tsas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire merge_ctl_t ctl,
  input  wire lane_res_t  x_res,
  input  wire lane_res_t  y_res,
  input  wire logic       out_ready,
  output logic            out_valid,
  output out_t            out_data
);

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_data_r.touch_ok    <= ctl.ok;
      out_data_r.x_out       <= ctl.ok ? x_res.value : '0;
      out_data_r.y_out       <= ctl.ok ? y_res.value : '0;
      out_data_r.x_low_seen  <= x_res.low;
      out_data_r.x_high_seen <= x_res.high;
      out_data_r.y_low_seen  <= y_res.low;
      out_data_r.y_high_seen <= y_res.high;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/tsas_checker.sv =====
// Port-level assertions for the touch averaging block, bound to the top level.
`default_nettype none
module tsas_checker
  import tsas_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire out_t              out_data
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // aborted burst reports zero coordinates
  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.touch_ok |-> out_data.x_out == '0 && out_data.y_out == '0)
    else $error("aborted burst with nonzero coordinates");

  // tracks start empty and, once touched, keep low at or below high
  a_track_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.x_low_seen <= out_data.x_high_seen) ||
       (out_data.x_low_seen == '1 && out_data.x_high_seen == '0)) &&
      ((out_data.y_low_seen <= out_data.y_high_seen) ||
       (out_data.y_low_seen == '1 && out_data.y_high_seen == '0)))
    else $error("tracked extremes out of order");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_sample_average_scale tsas_checker u_tsas_checker (.*);
`default_nettype wire

// ===== tb/touch_sample_average_scale_checker.sv =====
// Checker for touch_sample_average_scale: tracks registers, predicts burst reports, compares them.
module touch_sample_average_scale_checker
  import tsas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire in_t               in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  output int                     fail_count,
  output int                     reports_pending,
  output int                     samples_taken,
  output int                     full_bursts,
  output int                     raw_bursts,
  output int                     aborted_bursts
);
  timeunit 1ns;
  timeprecision 1ps;

  // register shadow
  logic [DATA_W-1:0] win_lo_x, win_hi_x, win_lo_y, win_hi_y;
  logic [DATA_W-1:0] screen_x, screen_y;
  logic              raw_mode;

  // burst accumulation and extreme tracks
  logic [SUM_W-1:0]  sum_x, sum_y;
  int                burst_fill;
  logic [DATA_W-1:0] low_x, high_x, low_y, high_y;

  out_t              report_q[$];
  out_t              want;

  function automatic logic [DATA_W-1:0] map_to_screen(input logic [DATA_W-1:0] mean,
                                                     input logic [DATA_W-1:0] lo,
                                                     input logic [DATA_W-1:0] hi,
                                                     input logic [DATA_W-1:0] span);
    logic [31:0] pos;
    logic [31:0] quot;
    if (hi <= lo) return '0;
    pos = 32'(mean);
    if (pos < 32'(lo)) pos = 32'(lo);
    if (pos > 32'(hi)) pos = 32'(hi);
    quot = ((pos - 32'(lo)) * 32'(span)) / (32'(hi) - 32'(lo));
    return quot[DATA_W-1:0];
  endfunction

  task automatic predict_report(input in_t s);
    out_t              r;
    logic [DATA_W-1:0] mean_x, mean_y;
    r = '0;
    if (!s.pressed) begin
      // release with nothing summed is silent
      if (burst_fill == 0) return;
      aborted_bursts++;
    end else begin
      sum_x = sum_x + {{CNT_W{1'b0}}, s.x_sample};
      sum_y = sum_y + {{CNT_W{1'b0}}, s.y_sample};
      burst_fill++;
      if (burst_fill < BURST_LEN) return;
      mean_x = DATA_W'(32'(sum_x) / 32'(BURST_LEN));
      mean_y = DATA_W'(32'(sum_y) / 32'(BURST_LEN));
      r.touch_ok = 1'b1;
      full_bursts++;
      if (raw_mode) begin
        raw_bursts++;
        if (mean_x < low_x)  low_x  = mean_x;
        if (mean_x > high_x) high_x = mean_x;
        if (mean_y < low_y)  low_y  = mean_y;
        if (mean_y > high_y) high_y = mean_y;
        r.x_out = mean_x;
        r.y_out = mean_y;
      end else begin
        r.x_out = map_to_screen(mean_x, win_lo_x, win_hi_x, screen_x);
        r.y_out = map_to_screen(mean_y, win_lo_y, win_hi_y, screen_y);
      end
    end
    sum_x = '0;
    sum_y = '0;
    burst_fill = 0;
    r.x_low_seen  = low_x;
    r.x_high_seen = high_x;
    r.y_low_seen  = low_y;
    r.y_high_seen = high_y;
    report_q.push_back(r);
  endtask

  task automatic check_field(input string label, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_lo_x = '0;
      win_hi_x = '1;
      win_lo_y = '0;
      win_hi_y = '1;
      screen_x = 16'd240;
      screen_y = 16'd320;
      raw_mode = 1'b0;
      sum_x = '0;
      sum_y = '0;
      burst_fill = 0;
      low_x = '1;
      high_x = '0;
      low_y = '1;
      high_y = '0;
      report_q.delete();
      fail_count = 0;
      reports_pending = 0;
      samples_taken = 0;
      full_bursts = 0;
      raw_bursts = 0;
      aborted_bursts = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_X:      win_lo_x = cfg_wdata;
          REG_MAX_X:      win_hi_x = cfg_wdata;
          REG_MIN_Y:      win_lo_y = cfg_wdata;
          REG_MAX_Y:      win_hi_y = cfg_wdata;
          REG_SCALE_X:    screen_x = cfg_wdata;
          REG_SCALE_Y:    screen_y = cfg_wdata;
          REG_REPORT_RAW: raw_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        samples_taken++;
        predict_report(in_data);
      end
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("touch_ok", DATA_W'(want.touch_ok), DATA_W'(out_data.touch_ok));
          check_field("x_out", want.x_out, out_data.x_out);
          check_field("y_out", want.y_out, out_data.y_out);
          check_field("x_low_seen", want.x_low_seen, out_data.x_low_seen);
          check_field("x_high_seen", want.x_high_seen, out_data.x_high_seen);
          check_field("y_low_seen", want.y_low_seen, out_data.y_low_seen);
          check_field("y_high_seen", want.y_high_seen, out_data.y_high_seen);
        end
      end
      reports_pending = report_q.size();
    end
  end

endmodule

// ===== tb/tb_touch_sample_average_scale.sv =====
// Testbench top for touch_sample_average_scale: clock, reset, stimulus, register phases, verdict.
module tb_touch_sample_average_scale;
  import tsas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam int RAND_PHASES     = 12;
  localparam int PHASE_ITEMS     = 160;
  localparam int DRAIN_CYCLES    = 30;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 5000000;

  typedef enum int {SPREAD, STEADY, JITTER, ALL_ZERO, ALL_ONES} fill_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [DATA_W-1:0] cfg_wdata;

  int fail_count, reports_pending, samples_taken, full_bursts, raw_bursts, aborted_bursts;
  int settings_applied;
  int cycle_count;
  bit hold_off_request;
  bit hold_off_done;
  bit no_gaps;

  touch_sample_average_scale i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  touch_sample_average_scale_checker i_touch_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .reports_pending (reports_pending),
    .samples_taken   (samples_taken),
    .full_bursts     (full_bursts),
    .raw_bursts      (raw_bursts),
    .aborted_bursts  (aborted_bursts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("touch_sample_average_scale test failed");
    $finish;
  end

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    int pick;
    int run;
    out_ready = 1'b0;
    hold_off_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_request && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_ready <= 1'b1;
          run = $urandom_range(1, 40);
        end else if (pick < 90) begin
          out_ready <= 1'b0;
          run = $urandom_range(1, 4);
        end else if (pick < 97) begin
          out_ready <= 1'b0;
          run = $urandom_range(5, 20);
        end else begin
          out_ready <= 1'b0;
          run = $urandom_range(30, 90);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic fill_t pick_fill();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return SPREAD;
    if (r < 50) return STEADY;
    if (r < 85) return JITTER;
    if (r < 92) return ALL_ZERO;
    return ALL_ONES;
  endfunction

  function automatic logic [DATA_W-1:0] burst_value(input fill_t fill,
                                                   input logic [DATA_W-1:0] base);
    case (fill)
      SPREAD:   return DATA_W'($urandom_range(0, 16'hFFFF));
      STEADY:   return base;
      JITTER:   return base ^ DATA_W'($urandom_range(0, 63));
      ALL_ZERO: return '0;
      default:  return '1;
    endcase
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_sample(input logic touch, input logic [DATA_W-1:0] xs,
                             input logic [DATA_W-1:0] ys);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pressed: touch, x_sample: xs, y_sample: ys};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_burst(input int len, input bit released);
    fill_t             fill_x, fill_y;
    logic [DATA_W-1:0] base_x, base_y;
    fill_x = pick_fill();
    fill_y = pick_fill();
    base_x = DATA_W'($urandom_range(0, 16'hFFFF));
    base_y = DATA_W'($urandom_range(0, 16'hFFFF));
    for (int i = 0; i < len; i++)
      send_sample(1'b1, burst_value(fill_x, base_x), burst_value(fill_y, base_y));
    if (released)
      send_sample(1'b0, DATA_W'($urandom_range(0, 16'hFFFF)),
                  DATA_W'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int phase);
    logic [DATA_W-1:0] lo_x, hi_x, lo_y, hi_y, sc_x, sc_y, swap;
    logic [14:0]       junk;
    logic              raw;
    lo_x = DATA_W'($urandom_range(0, 16'hFFFF));
    hi_x = DATA_W'($urandom_range(0, 16'hFFFF));
    lo_y = DATA_W'($urandom_range(0, 16'hFFFF));
    hi_y = DATA_W'($urandom_range(0, 16'hFFFF));
    // mostly proper windows, some inverted
    if (lo_x > hi_x && $urandom_range(0, 3) != 0) begin
      swap = lo_x;
      lo_x = hi_x;
      hi_x = swap;
    end
    if (lo_y > hi_y && $urandom_range(0, 3) != 0) begin
      swap = lo_y;
      lo_y = hi_y;
      hi_y = swap;
    end
    sc_x = DATA_W'($urandom_range(1, 16'hFFFF));
    sc_y = DATA_W'($urandom_range(1, 16'hFFFF));
    raw  = 1'($urandom_range(0, 1));
    junk = 15'($urandom);
    case (phase)
      0: begin
        lo_x = '0; hi_x = '1; lo_y = '0; hi_y = '1; sc_x = 16'd240; sc_y = 16'd320; raw = 1'b0;
      end
      1: begin
        lo_x = '0; hi_x = '1; lo_y = '0; hi_y = '1; sc_x = '1; sc_y = '1; raw = 1'b0;
      end
      2: begin
        // X window empty, Y window inverted
        lo_x = 16'h8000; hi_x = 16'h8000; lo_y = 16'h9000; hi_y = 16'h1000;
        sc_x = 16'd1; sc_y = 16'd1; raw = 1'b0;
      end
      3: raw = 1'b1;
      4: begin
        lo_x = 16'h7FC0; hi_x = 16'h8040; lo_y = 16'h7000; hi_y = 16'h9000;
        sc_x = 16'd1000; sc_y = '0; raw = 1'b0;
      end
      5: begin
        lo_x = 16'hFFFE; hi_x = '1; lo_y = '0; hi_y = 16'd1; sc_x = '1; sc_y = '1; raw = 1'b0;
      end
      6: raw = 1'b1;
      default: ;
    endcase
    write_reg(REG_MIN_X, lo_x);
    write_reg(REG_MAX_X, hi_x);
    write_reg(REG_MIN_Y, lo_y);
    write_reg(REG_MAX_Y, hi_y);
    write_reg(REG_SCALE_X, sc_x);
    write_reg(REG_SCALE_Y, sc_y);
    write_reg(REG_REPORT_RAW, {junk, raw});
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, DATA_W'($urandom_range(0, 16'hFFFF)));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int pick;
    int len;
    int sent;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    no_gaps   = 1'b0;
    hold_off_request = 1'b0;
    settings_applied = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle release, aborted burst, mode switch mid-burst
    send_sample(1'b0, '1, '1);
    repeat (3) send_sample(1'b1, '0, '1);
    send_sample(1'b0, '0, '0);
    repeat (8) send_sample(1'b1, '1, '1);
    wait_quiet();
    write_reg(REG_REPORT_RAW, 16'h0003);
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    settings_applied++;
    repeat (8) send_sample(1'b1, '1, '1);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_quiet();
      apply_setting(phase);
      no_gaps = (phase % 4 == 3);
      if (phase == 0) hold_off_request = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_burst(BURST_LEN, 1'b0);
          sent += BURST_LEN;
        end else if (pick < 94) begin
          len = $urandom_range(1, BURST_LEN - 1);
          send_burst(len, 1'b1);
          sent += len + 1;
        end else begin
          // release between bursts, ignored by the block
          send_sample(1'b0, DATA_W'($urandom_range(0, 16'hFFFF)),
                      DATA_W'($urandom_range(0, 16'hFFFF)));
          sent++;
        end
      end
    end
    wait_quiet();

    $display("Run covered %0d sample transactions under %0d register settings.",
             samples_taken, settings_applied);
    $display("Reports: %0d full bursts (%0d in raw mode), %0d bursts cut short by release.",
             full_bursts, raw_bursts, aborted_bursts);
    if (fail_count == 0)
      $display("touch_sample_average_scale test passed");
    else
      $display("touch_sample_average_scale test failed");
    $finish;
  end

endmodule
